FILE: rtl/kmsmt_pkg.sv
// Shared constants for the key matrix scanner with mode toggles.
// Scan phase codes, key word layout and reset values. No dependencies.
package kmsmt_pkg;

	localparam int PinW  = 9;
	localparam int KeyW  = 14;
	localparam int LoW   = 5;
	localparam int HoldW = 8;
	localparam int ModeW = 5;

	typedef logic [1:0] phase_t;
	localparam phase_t PhLatchLo = 2'd0;
	localparam phase_t PhSelB    = 2'd1;
	localparam phase_t PhLatchHi = 2'd2;
	localparam phase_t PhSelA    = 2'd3;

	// key positions used by the mode logic
	localparam int KeyMode0 = 1;
	localparam int KeyMode1 = 6;
	localparam int KeyMode2 = 2;
	localparam int KeyMode3 = 7;
	localparam int KeyVentOn  = 3;
	localparam int KeyVentOff = 8;
	localparam int ModeVent   = 4;

	localparam logic [HoldW-1:0] HoldReset  = 8'd30;
	localparam logic [HoldW-1:0] TimerReset = 8'd5;
	localparam logic [ModeW-1:0] ModeReset  = 5'h10;

endpackage

FILE: rtl/key_matrix_scan_mode_toggle_unit.sv
// Top level of the key matrix scanner with mode toggles.
// Uses kmsmt_pkg for phase codes, key positions and reset values.
//
// Each input transfer is one timer tick carrying the nine active-low pin
// levels. The block runs a four-phase scan (3,2,1,0, repeating): phase 3
// pulls select A low, phase 1 pulls select B low, phase 0 latches the five
// low keys and phase 2 latches the nine high keys. A 14-bit sample that
// matches the previous one becomes the debounced key word; new presses stay
// pending for hold_ticks_q ticks and toggle mode bits 0-3, while keys 3
// and 8 set and clear the ventilation bit 4. One tick is taken per clock,
// sustained: the tick sits in an input register, a single pass of bitwise
// logic updates the scan state, and the result register is the scan state
// itself, so out_valid is set as the tick leaves the input register. The
// only limit on rate is the result register: while a result waits to be
// taken, one more tick is held in the input register and input ready drops.
// The hold register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, which the block itself does not enforce.
module key_matrix_scan_mode_toggle_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [kmsmt_pkg::HoldW-1:0]     cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [kmsmt_pkg::PinW-1:0]      pin_levels,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            select_a_n,
	output logic                            select_b_n,
	output logic [kmsmt_pkg::KeyW-1:0]      stable_keys,
	output logic [kmsmt_pkg::ModeW-1:0]     mode_word
);
	import kmsmt_pkg::*;

	// configuration
	logic [HoldW-1:0] hold_ticks_q;

	// input register
	logic            valid_s1;
	logic [PinW-1:0] pins_s1;

	// scan state; the select, stable and mode registers double as the result
	phase_t           phase_q;
	logic [KeyW-1:0]  sample_q;
	logic [KeyW-1:0]  stable_q;
	logic [KeyW-1:0]  pending_q;
	logic [HoldW-1:0] timer_q;
	logic [ModeW-1:0] mode_q;
	logic             sel_a_q;
	logic             sel_b_q;
	logic             out_valid_q;

	// next-state values
	phase_t           phase_d;
	logic [KeyW-1:0]  sample_d;
	logic [KeyW-1:0]  stable_d;
	logic [KeyW-1:0]  pending_d;
	logic [HoldW-1:0] timer_d;
	logic [ModeW-1:0] mode_d;
	logic             sel_a_d;
	logic             sel_b_d;
	logic [PinW-1:0]  keys_all;
	logic [KeyW-1:0]  word;
	logic [KeyW-1:0]  rising;
	logic             advance;

	// the tick leaves the input register whenever the result slot is free
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	assign select_a_n  = sel_a_q;
	assign select_b_n  = sel_b_q;
	assign stable_keys = stable_q;
	assign mode_word   = mode_q;

	assign keys_all = ~pins_s1;
	assign word     = {keys_all, sample_q[LoW-1:0]};
	assign rising   = word & ~stable_q;

	always_comb begin
		sample_d  = sample_q;
		stable_d  = stable_q;
		pending_d = pending_q;
		sel_a_d   = sel_a_q;
		sel_b_d   = sel_b_q;
		timer_d   = (timer_q != '0) ? timer_q - 1'b1 : timer_q;
		// two-bit decrement wraps 0 to 3
		phase_d   = phase_q - 1'b1;

		unique case (phase_d)
			PhLatchLo: begin
				sample_d = {sample_q[KeyW-1:LoW], keys_all[LoW-1:0]};
			end
			PhSelB: begin
				sel_a_d = 1'b1;
				sel_b_d = 1'b0;
			end
			PhLatchHi: begin
				if (word == sample_q) begin
					stable_d = word;
					if (rising != '0) begin
						pending_d = pending_q | rising;
						timer_d   = hold_ticks_q;
					end
				end
				if (timer_d == '0)
					pending_d = '0;
				sample_d = word;
			end
			PhSelA: begin
				sel_a_d = 1'b0;
				sel_b_d = 1'b1;
			end
			default: begin
			end
		endcase

		// pending presses toggle mode bits and are consumed
		mode_d = mode_q;
		mode_d[0] = mode_q[0] ^ pending_d[KeyMode0];
		mode_d[1] = mode_q[1] ^ pending_d[KeyMode1];
		mode_d[2] = mode_q[2] ^ pending_d[KeyMode2];
		mode_d[3] = mode_q[3] ^ pending_d[KeyMode3];
		pending_d[KeyMode0] = 1'b0;
		pending_d[KeyMode1] = 1'b0;
		pending_d[KeyMode2] = 1'b0;
		pending_d[KeyMode3] = 1'b0;

		// ventilation: on-key wins over off-key
		priority if (stable_d[KeyVentOn])
			mode_d[ModeVent] = 1'b1;
		else if (stable_d[KeyVentOff])
			mode_d[ModeVent] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HoldReset;
		end else if (cfg_wr_en) begin
			hold_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			pins_s1 <= pin_levels;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PhLatchLo;
			sample_q    <= '0;
			stable_q    <= '0;
			pending_q   <= '0;
			timer_q     <= TimerReset;
			mode_q      <= ModeReset;
			sel_a_q     <= 1'b1;
			sel_b_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q   <= phase_d;
				sample_q  <= sample_d;
				stable_q  <= stable_d;
				pending_q <= pending_d;
				timer_q   <= timer_d;
				mode_q    <= mode_d;
				sel_a_q   <= sel_a_d;
				sel_b_q   <= sel_b_d;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: tb/sv/key_matrix_scan_mode_toggle_unit_tb.sv
// Self-checking testbench for key_matrix_scan_mode_toggle_unit.
// Holds its own scan and mode-toggle predictor in a small scoreboard class.
// Depends on kmsmt_pkg for widths, phase codes, key positions and reset values.
module key_matrix_scan_mode_toggle_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kmsmt_pkg::*;

	// One result transfer: select lines, debounced keys, mode bits.
	typedef struct packed {
		logic              sel_a;
		logic              sel_b;
		logic [KeyW-1:0]   keys;
		logic [ModeW-1:0]  mode;
	} scan_result_t;

	// Cycles without any transfer before the run is declared hung. The longest
	// legitimate quiet stretch is the receiver hold-off (HoldOffCycles).
	localparam int unsigned QuietLimit = 2000;
	localparam int unsigned HoldOffCycles = 80;
	localparam int unsigned FramesPerHalf = 40;

	// Tracks scan state tick by tick and keeps the results still owed by the block.
	class scan_scoreboard;
		logic [HoldW-1:0] hold_ticks;
		phase_t           phase;
		logic [KeyW-1:0]  sample;
		logic [KeyW-1:0]  stable;
		logic [KeyW-1:0]  pending;
		logic [HoldW-1:0] timer;
		logic [ModeW-1:0] mode;
		logic             sel_a;
		logic             sel_b;
		scan_result_t     due[$];
		int unsigned      errors;

		function void reset_scan();
			hold_ticks = HoldReset;
			phase      = PhLatchLo;
			sample     = '0;
			stable     = '0;
			pending    = '0;
			timer      = TimerReset;
			mode       = ModeReset;
			sel_a      = 1'b1;
			sel_b      = 1'b1;
			errors     = 0;
			due.delete();
		endfunction

		function void set_hold(logic [HoldW-1:0] value);
			hold_ticks = value;
		endfunction

		// One accepted tick: advance the scan, run the mode logic, queue the result.
		function void note_tick(logic [PinW-1:0] pins);
			logic [KeyW-1:0] word;
			logic [KeyW-1:0] rising;
			int unsigned     toggle_key [4];
			scan_result_t    res;
			toggle_key = '{KeyMode0, KeyMode1, KeyMode2, KeyMode3};

			if (timer != 0)
				timer = timer - 1'b1;
			phase = (phase == PhLatchLo) ? PhSelA : phase_t'(phase - 1'b1);

			case (phase)
				PhLatchLo: begin
					sample[LoW-1:0] = ~pins[LoW-1:0];
				end
				PhSelB: begin
					sel_a = 1'b1;
					sel_b = 1'b0;
				end
				PhLatchHi: begin
					word = {~pins, sample[LoW-1:0]};
					if (word == sample) begin
						rising = word & ~stable;
						stable = word;
						if (rising != '0) begin
							pending |= rising;
							timer = hold_ticks;
						end
					end
					if (timer == 0)
						pending = '0;
					sample = word;
				end
				default: begin
					sel_a = 1'b0;
					sel_b = 1'b1;
				end
			endcase

			// pending presses toggle mode bits 0-3 and are consumed
			for (int i = 0; i < 4; i++) begin
				if (pending[toggle_key[i]]) begin
					mode[i] = ~mode[i];
					pending[toggle_key[i]] = 1'b0;
				end
			end
			if (stable[KeyVentOn])
				mode[ModeVent] = 1'b1;
			else if (stable[KeyVentOff])
				mode[ModeVent] = 1'b0;

			res.sel_a = sel_a;
			res.sel_b = sel_b;
			res.keys  = stable;
			res.mode  = mode;
			due.push_back(res);
		endfunction

		function void check_result(scan_result_t got);
			scan_result_t want;
			if (due.size() == 0) begin
				$error("result with no tick outstanding: keys %h mode %h", got.keys, got.mode);
				errors++;
				return;
			end
			want = due.pop_front();
			if (got.sel_a !== want.sel_a) begin
				$error("select_a_n: expected %0d, got %0d", want.sel_a, got.sel_a);
				errors++;
			end
			if (got.sel_b !== want.sel_b) begin
				$error("select_b_n: expected %0d, got %0d", want.sel_b, got.sel_b);
				errors++;
			end
			if (got.keys !== want.keys) begin
				$error("stable_keys: expected %h, got %h", want.keys, got.keys);
				errors++;
			end
			if (got.mode !== want.mode) begin
				$error("mode_word: expected %h, got %h", want.mode, got.mode);
				errors++;
			end
		endfunction
	endclass

	// All block inputs start at known values.
	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [HoldW-1:0]  cfg_wr_data = '0;
	logic              in_valid    = 1'b0;
	logic [PinW-1:0]   pin_levels  = '1;
	logic              out_ready   = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic              select_a_n;
	logic              select_b_n;
	logic [KeyW-1:0]   stable_keys;
	logic [ModeW-1:0]  mode_word;

	scan_scoreboard board = new;

	// State of the sender, receiver and watchdog processes.
	bit          no_idle     = 1'b0;   // long stretch with no gaps on either side
	bit          stall_req   = 1'b0;   // sender asks the receiver for one long hold-off
	bit          stall_taken = 1'b0;   // receiver has started that hold-off
	int unsigned stall_left  = 0;
	int unsigned quiet_cycles = 0;

	key_matrix_scan_mode_toggle_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pin_levels  (pin_levels),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.select_a_n  (select_a_n),
		.select_b_n  (select_b_n),
		.stable_keys (stable_keys),
		.mode_word   (mode_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: checks every result transfer, then picks ready for the next cycle.
	// Handshake values are read right after the edge, before any update lands.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(scan_result_t'{select_a_n, select_b_n, stable_keys, mode_word});
		if (stall_left != 0) begin
			// hold-off in progress: the block fills and drops in_ready
			stall_left--;
			out_ready <= 1'b0;
		end else if (stall_req && !stall_taken) begin
			stall_taken = 1'b1;
			stall_left  = HoldOffCycles;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99, 0) >= 21);
		end
	end

	// Watchdog: counts cycles in which no transfer happens on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("key_matrix_scan_mode_toggle_unit_tb: FAIL");
				$finish;
			end
		end
	end

	// One tick transfer. Valid stays up with the payload fixed until accepted;
	// a gap may follow at random, so gaps land on every scan phase.
	task automatic send_tick(input logic [PinW-1:0] pins);
		in_valid   <= 1'b1;
		pin_levels <= pins;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_tick(pins);
		if (!no_idle) begin
			// each cycle idles with the same odds, so gaps come out geometric
			while ($urandom_range(99, 0) < 21) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// One scan frame, four ticks in phase order 3,2,1,0. The key word is laid
	// out so that phase 2 sees the nine high keys and phase 0 the five low ones.
	// Select phases carry random pins, which the block ignores.
	task automatic send_frame(input logic [KeyW-1:0] keys, input bit noise);
		logic [PinW-1:0] hi_pins;
		logic [PinW-1:0] lo_pins;
		hi_pins = noise ? PinW'($urandom) : ~keys[KeyW-1:LoW];
		lo_pins = noise ? PinW'($urandom) : {4'($urandom), ~keys[LoW-1:0]};
		send_tick(PinW'($urandom));
		send_tick(hi_pins);
		send_tick(PinW'($urandom));
		send_tick(lo_pins);
	endtask

	// Mostly held key patterns (a pattern must survive two phase-2 samples to
	// debounce); a hold of one frame is a broken press, and some frames are noise.
	task automatic run_frames(input int unsigned count);
		int unsigned     done_frames;
		int unsigned     reps;
		logic [KeyW-1:0] keys;
		done_frames = 0;
		while (done_frames < count) begin
			if ($urandom_range(99, 0) < 20) begin
				send_frame('0, 1'b1);
				done_frames++;
			end else begin
				// sparse patterns make single toggles likely, dense ones chords
				if ($urandom_range(1, 0) != 0)
					keys = KeyW'($urandom & $urandom & $urandom);
				else
					keys = KeyW'($urandom);
				reps = $urandom_range(4, 1);
				repeat (reps) send_frame(keys, 1'b0);
				done_frames += reps;
			end
		end
	endtask

	// Stop offering ticks until every owed result has arrived, then let
	// the pipeline settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write, only while the block is idle.
	task automatic write_hold(input logic [HoldW-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		board.set_hold(value);
	endtask

	initial begin
		logic [HoldW-1:0] hold_plan [5];

		board.reset_scan();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every key pressed (all pins low), every key released (all
		// pins high), then the ventilation-off key alone. Two frames each so the
		// pattern debounces. All-pressed has both ventilation keys: set wins.
		write_hold(HoldReset);
		send_frame('1, 1'b0);
		send_frame('1, 1'b0);
		send_frame('0, 1'b0);
		send_frame('0, 1'b0);
		send_frame(KeyW'(1) << KeyVentOff, 1'b0);
		send_frame(KeyW'(1) << KeyVentOff, 1'b0);
		wait_drained();

		// Hold settings: shortest nonzero, longest, zero (presses dropped at once),
		// a random middle value, back to the reset value.
		hold_plan = '{8'd1, 8'd255, 8'd0, HoldW'($urandom_range(254, 2)), HoldReset};
		for (int p = 0; p < 5; p++) begin
			write_hold(hold_plan[p]);
			no_idle = (p == 3);
			run_frames(FramesPerHalf);
			if (p == 1)
				stall_req = 1'b1;   // receiver holds off while ticks keep coming
			if (p == 2)
				wait_drained();     // sender pauses until nothing is owed
			run_frames(FramesPerHalf);
			no_idle = 1'b0;
			wait_drained();
		end

		repeat (4) @(posedge clk);
		if (board.errors == 0 && board.due.size() == 0)
			$display("key_matrix_scan_mode_toggle_unit_tb: PASS");
		else
			$display("key_matrix_scan_mode_toggle_unit_tb: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/kmsmt_pkg.sv
rtl/key_matrix_scan_mode_toggle_unit.sv
tb/sv/key_matrix_scan_mode_toggle_unit_tb.sv
